### design/euler_to_rotation_matrix_defines.svh
// ---------------------------------------------------------------------------
// euler_to_rotation_matrix assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef EULER_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_DEFINES_SVH

`ifndef NO_ASSERTIONS
// prop must hold at every clock edge outside reset
`define E2R_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("e2r check failed");
// cond must never be true outside reset
`define E2R_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("e2r forbidden condition");
`else
`define E2R_ASSERT(lbl, prop)
`define E2R_NEVER(lbl, cond)
`endif

`endif

### design/e2r_pkg.sv
// ---------------------------------------------------------------------------
// e2r_pkg
// Types and constants shared by the Euler-to-rotation-matrix pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package e2r_pkg;

    localparam int ANGLE_BITS     = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_W         = COEF_FRAC_BITS + 2;
    localparam int CORDIC_STEPS   = 24;
    localparam int TURN_W         = 32;     // internal angle: 2^32 = one turn
    localparam int Q              = 30;     // sin/cos fraction bits
    localparam int PROD_W         = 64;

    localparam logic signed [TURN_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] bank_angle;
        logic signed [ANGLE_BITS-1:0] attitude_angle;
        logic signed [ANGLE_BITS-1:0] heading_angle;
    } t_angles;

    typedef struct packed {
        logic signed [COEF_W-1:0] r00;
        logic signed [COEF_W-1:0] r01;
        logic signed [COEF_W-1:0] r02;
        logic signed [COEF_W-1:0] r10;
        logic signed [COEF_W-1:0] r11;
        logic signed [COEF_W-1:0] r12;
        logic signed [COEF_W-1:0] r20;
        logic signed [COEF_W-1:0] r21;
        logic signed [COEF_W-1:0] r22;
    } t_matrix;

    // one rotation lane of a cell
    typedef struct packed {
        logic signed [TURN_W-1:0] x;
        logic signed [TURN_W-1:0] y;
        logic signed [TURN_W-1:0] z;
        logic [1:0]               quad;
    } t_lane;

    // lane 0 bank, lane 1 attitude, lane 2 heading
    typedef struct packed {
        logic            vld;
        t_lane [2:0]     lane;
    } t_cordic_beat;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic signed [TURN_W-1:0] atan_turn(input int step);
        logic signed [TURN_W-1:0] v;
        case (step)
            0:  v = 32'sd536870912;
            1:  v = 32'sd316933406;
            2:  v = 32'sd167458907;
            3:  v = 32'sd85004756;
            4:  v = 32'sd42667331;
            5:  v = 32'sd21354465;
            6:  v = 32'sd10679838;
            7:  v = 32'sd5340245;
            8:  v = 32'sd2670163;
            9:  v = 32'sd1335087;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/e2r_cell.sv
// ---------------------------------------------------------------------------
// e2r_cell
// One CORDIC rotation step for all three angles, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module e2r_cell #(
    parameter int STEP = 0
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  e2r_pkg::t_cordic_beat   i_beat,
    output e2r_pkg::t_cordic_beat   o_beat
);
    import e2r_pkg::*;

    localparam logic signed [TURN_W-1:0] ATAN = atan_turn(STEP);

    t_cordic_beat r_beat, n_beat;

    always_comb begin
        logic signed [TURN_W-1:0] dx, dy;
        n_beat = i_beat;
        for (int k = 0; k < 3; k++) begin
            dx = i_beat.lane[k].y >>> STEP;
            dy = i_beat.lane[k].x >>> STEP;
            if (!i_beat.lane[k].z[TURN_W-1]) begin
                n_beat.lane[k].x = i_beat.lane[k].x - dx;
                n_beat.lane[k].y = i_beat.lane[k].y + dy;
                n_beat.lane[k].z = i_beat.lane[k].z - ATAN;
            end else begin
                n_beat.lane[k].x = i_beat.lane[k].x + dx;
                n_beat.lane[k].y = i_beat.lane[k].y - dy;
                n_beat.lane[k].z = i_beat.lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat.lane <= n_beat.lane;
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
        end else begin
            r_beat.vld <= n_beat.vld;
        end
    end

    assign o_beat = r_beat;

endmodule

`default_nettype wire

### design/e2r_matrix.sv
// ---------------------------------------------------------------------------
// e2r_matrix
// Quadrant fold, products, sums, rounding and saturation to Q1.14.
// ---------------------------------------------------------------------------
`default_nettype none

module e2r_matrix (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  e2r_pkg::t_cordic_beat   i_beat,
    output logic                    o_done,
    output e2r_pkg::t_matrix        o_matrix
);
    import e2r_pkg::*;

    localparam int SH = 2 * Q - COEF_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RND60 = 64'sd1 <<< (SH - 1);
    localparam logic signed [PROD_W-1:0] RND30 = 64'sd1 <<< (Q - 1);
    localparam logic signed [PROD_W-1:0] LIM   = 64'sd1 <<< COEF_FRAC_BITS;

    typedef logic signed [TURN_W-1:0] t_q30;
    typedef logic signed [PROD_W-1:0] t_q60;

    logic [5:0] r_vld;

    // stage 0: sin/cos
    t_q30 r_c [3], r_s [3];
    // stage 1
    t_q60 r_chca, r_cacb, r_casb, r_shca, r_shsb, r_chsb, r_shcb, r_chcb;
    t_q60 r_p_sacb, r_p_sasb;
    t_q30 r1_ch, r1_sh, r1_sa;
    // stage 2
    t_q60 r2_chca, r2_cacb, r2_casb, r2_shca, r2_shsb, r2_chsb, r2_shcb, r2_chcb;
    t_q30 r_sacb, r_sasb, r2_ch, r2_sh, r2_sa;
    // stage 3
    t_q60 r3_chca, r3_cacb, r3_casb, r3_shca, r3_shsb, r3_chsb, r3_shcb, r3_chcb;
    t_q60 r_chsacb, r_shsacb, r_chsasb, r_shsasb;
    t_q30 r3_sa;
    // stage 4
    t_q60 r_sum [9];
    // stage 5
    t_matrix r_mat;

    function automatic logic signed [COEF_W-1:0] finish(input t_q60 v);
        t_q60 t;
        t = (v + RND60) >>> SH;
        if (t > LIM) t = LIM;
        if (t < -LIM) t = -LIM;
        return t[COEF_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        // quadrant fold
        for (int k = 0; k < 3; k++) begin
            case (i_beat.lane[k].quad)
                QUAD_0: begin r_c[k] <= i_beat.lane[k].x;  r_s[k] <= i_beat.lane[k].y;  end
                QUAD_1: begin r_c[k] <= -i_beat.lane[k].y; r_s[k] <= i_beat.lane[k].x;  end
                QUAD_2: begin r_c[k] <= -i_beat.lane[k].x; r_s[k] <= -i_beat.lane[k].y; end
                default: begin r_c[k] <= i_beat.lane[k].y; r_s[k] <= -i_beat.lane[k].x; end
            endcase
        end
        // lanes: 0 bank (b), 1 attitude (a), 2 heading (h)
        r_chca   <= r_c[2] * r_c[1];
        r_cacb   <= r_c[1] * r_c[0];
        r_casb   <= r_c[1] * r_s[0];
        r_shca   <= r_s[2] * r_c[1];
        r_shsb   <= r_s[2] * r_s[0];
        r_chsb   <= r_c[2] * r_s[0];
        r_shcb   <= r_s[2] * r_c[0];
        r_chcb   <= r_c[2] * r_c[0];
        r_p_sacb <= r_s[1] * r_c[0];
        r_p_sasb <= r_s[1] * r_s[0];
        r1_ch    <= r_c[2];
        r1_sh    <= r_s[2];
        r1_sa    <= r_s[1];

        begin
            t_q60 ta, tb;
            ta = r_p_sacb + RND30;
            tb = r_p_sasb + RND30;
            r_sacb <= ta[Q+TURN_W-1:Q];
            r_sasb <= tb[Q+TURN_W-1:Q];
        end
        r2_chca <= r_chca; r2_cacb <= r_cacb; r2_casb <= r_casb; r2_shca <= r_shca;
        r2_shsb <= r_shsb; r2_chsb <= r_chsb; r2_shcb <= r_shcb; r2_chcb <= r_chcb;
        r2_ch <= r1_ch; r2_sh <= r1_sh; r2_sa <= r1_sa;

        r_chsacb <= r2_ch * r_sacb;
        r_shsacb <= r2_sh * r_sacb;
        r_chsasb <= r2_ch * r_sasb;
        r_shsasb <= r2_sh * r_sasb;
        r3_chca <= r2_chca; r3_cacb <= r2_cacb; r3_casb <= r2_casb; r3_shca <= r2_shca;
        r3_shsb <= r2_shsb; r3_chsb <= r2_chsb; r3_shcb <= r2_shcb; r3_chcb <= r2_chcb;
        r3_sa <= r2_sa;

        r_sum[0] <= r3_chca;
        r_sum[1] <= r3_shsb - r_chsacb;
        r_sum[2] <= r_chsasb + r3_shcb;
        r_sum[3] <= t_q60'(r3_sa) <<< Q;
        r_sum[4] <= r3_cacb;
        r_sum[5] <= -r3_casb;
        r_sum[6] <= -r3_shca;
        r_sum[7] <= r_shsacb + r3_chsb;
        r_sum[8] <= r3_chcb - r_shsasb;

        r_mat.r00 <= finish(r_sum[0]);
        r_mat.r01 <= finish(r_sum[1]);
        r_mat.r02 <= finish(r_sum[2]);
        r_mat.r10 <= finish(r_sum[3]);
        r_mat.r11 <= finish(r_sum[4]);
        r_mat.r12 <= finish(r_sum[5]);
        r_mat.r20 <= finish(r_sum[6]);
        r_mat.r21 <= finish(r_sum[7]);
        r_mat.r22 <= finish(r_sum[8]);

        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_beat.vld};
        end
    end

    assign o_done   = r_vld[5];
    assign o_matrix = r_mat;

endmodule

`default_nettype wire

### design/euler_to_rotation_matrix.sv
// ---------------------------------------------------------------------------
// euler_to_rotation_matrix
// Y-Z-X Euler angles to a 3x3 rotation matrix in signed Q1.14.
// ---------------------------------------------------------------------------
// Usage: drive i_angles and pulse i_start; a beat is taken at every edge with
// i_start high outside reset (o_busy is always low), so one set of angles per
// clock is sustained. Once a beat has passed through the pipeline, o_done is
// high for one cycle with the nine entries on o_matrix. There is no back-pressure: the
// receiver must capture o_matrix whenever o_done is high. The pipeline is
// a chain of 24 CORDIC cells (one rotation step each, all three angles
// side by side) followed by six product/sum/round stages. No state is kept
// between beats and there is no configuration.
// ---------------------------------------------------------------------------
`default_nettype none

`include "euler_to_rotation_matrix_defines.svh"

module euler_to_rotation_matrix (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    input  e2r_pkg::t_angles    i_angles,
    output logic                o_done,
    output e2r_pkg::t_matrix    o_matrix
);
    import e2r_pkg::*;

    localparam int LATENCY = CORDIC_STEPS + 6;
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);

    logic w_accept;
    t_cordic_beat w_chain [CORDIC_STEPS+1];
    logic signed [ANGLE_BITS-1:0] w_ang [3];

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy && i_rst_n;

    assign w_ang[0] = i_angles.bank_angle;
    assign w_ang[1] = i_angles.attitude_angle;
    assign w_ang[2] = i_angles.heading_angle;

    // Widen each angle to a 32-bit turn, strip the nearest quarter turn and
    // start the rotation from the CORDIC gain; the quadrant rides along.
    always_comb begin
        logic [TURN_W-1:0] a, qs;
        w_chain[0].vld = w_accept;
        for (int k = 0; k < 3; k++) begin
            a  = {w_ang[k], {(TURN_W-ANGLE_BITS){1'b0}}};
            qs = a + (TURN_W'(1) << (TURN_W - 3));
            w_chain[0].lane[k].quad = qs[TURN_W-1:TURN_W-2];
            w_chain[0].lane[k].z    = a - {qs[TURN_W-1:TURN_W-2], {(TURN_W-2){1'b0}}};
            w_chain[0].lane[k].x    = CORDIC_GAIN;
            w_chain[0].lane[k].y    = '0;
        end
    end

    // CORDIC cell chain
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        e2r_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_chain[g]),
            .o_beat  (w_chain[g+1])
        );
    end

    e2r_matrix u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (w_chain[CORDIC_STEPS]),
        .o_done   (o_done),
        .o_matrix (o_matrix)
    );

    // a result beat always traces back to a start beat a fixed time earlier
    `E2R_ASSERT(a_latency, o_done |-> $past(w_accept, LATENCY))
    `E2R_NEVER(a_never_busy, o_busy)
    `E2R_ASSERT(a_r11_range, o_done |-> (o_matrix.r11 <= COEF_ONE && o_matrix.r11 >= -COEF_ONE))

endmodule

`default_nettype wire
